/* src/csft_pkg.sv */
// ----------------------------------------------------------------------------
// csft_pkg
// Shared types and codes for the command slot fence tracker.
// ----------------------------------------------------------------------------
package csft_pkg;

    localparam int SLOT_W = 6;
    localparam int ID_W   = 32;
    localparam int REQ_W  = 3;
    localparam int STS_W  = 2;

    localparam logic [REQ_W-1:0] REQ_ACQUIRE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SUBMIT   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DEFER    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FLUSH    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COMPLETE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_QUERY    = 3'd5;

    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_BUSY     = 2'd1;
    localparam logic [STS_W-1:0] STS_BAD_SLOT = 2'd2;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_ENCODING = 2'd1,
        ST_PENDING  = 2'd2,
        ST_DEFERRED = 2'd3
    } t_slot_st;

    typedef struct packed {
        t_slot_st            st;
        logic [ID_W-1:0]     val;
    } t_entry;

    typedef enum logic [1:0] {
        RD_IDX = 2'd0,
        RD_REQ = 2'd1,
        RD_QUE = 2'd2
    } t_rd_src;

    typedef enum logic [2:0] {
        EM_NONE  = 3'd0,
        EM_BUSY  = 3'd1,
        EM_BAD   = 3'd2,
        EM_DONE  = 3'd3,
        EM_QUERY = 3'd4
    } t_emit;

    typedef struct packed {
        logic    latch;
        logic    idx_clr;
        logic    idx_inc;
        logic    rd_en;
        t_rd_src rd_src;
        logic    reap_rd;
        logic    que_rd;
        logic    set_completed;
        logic    take;
        logic    submit;
        logic    flush_out;
        logic    flush_clr;
        t_emit   emit;
    } t_dp_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             free_zero;
        logic             idx_last;
        logic             idx_free;
        logic             slot_ok;
        logic             dq_empty;
        logic             fl_last;
    } t_dp_sts;

endpackage

/* src/csft_dp.sv */
// ----------------------------------------------------------------------------
// csft_dp
// Datapath: slot memory, deferred queue, valid bits, counters, result word.
// ----------------------------------------------------------------------------
module csft_dp import csft_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [SLOT_W-1:0] i_slot_index,
    input  logic [ID_W-1:0]   i_fence_value,
    input  logic [ID_W-1:0]   i_query_id,
    input  logic              i_is_query,
    output logic              o_valid,
    output logic [STS_W-1:0]  o_status,
    output logic [SLOT_W-1:0] o_slot_out,
    output logic [ID_W-1:0]   o_submit_id,
    output logic              o_commit,
    output logic              o_ready_res,
    output logic              o_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);

    t_entry             r_mem [SLOTS];
    logic [IDX_W-1:0]   r_que [SLOTS];

    logic [REQ_W-1:0]   r_req;
    logic [SLOT_W-1:0]  r_slot_idx;
    logic               r_slot_in;
    logic [ID_W-1:0]    r_fence;
    logic [ID_W-1:0]    r_qid;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_rd_addr;
    t_entry             r_rd_data;
    logic [IDX_W-1:0]   r_que_q;
    logic               r_reap_pend;
    logic [SLOTS-1:0]   r_vld;
    logic [CNT_W-1:0]   r_free;
    logic [ID_W-1:0]    r_counter;
    logic [ID_W-1:0]    r_completed;
    logic [CNT_W-1:0]   r_dcount;

    logic               r_o_valid;
    logic [STS_W-1:0]   r_o_status;
    logic [SLOT_W-1:0]  r_o_slot;
    logic [ID_W-1:0]    r_o_id;
    logic               r_o_commit;
    logic               r_o_ready;
    logic               r_o_last;

    logic               n_o_valid;
    logic [STS_W-1:0]   n_o_status;
    logic [SLOT_W-1:0]  n_o_slot;
    logic [ID_W-1:0]    n_o_id;
    logic               n_o_commit;
    logic               n_o_ready;
    logic               n_o_last;
    logic [ID_W-1:0]    n_counter;

    logic [IDX_W-1:0]   slot_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    t_entry             mem_wd;
    logic               que_we;
    logic               reap_free;
    logic               fl_last;

    assign slot_addr = r_slot_idx[IDX_W-1:0];
    assign fl_last   = (CNT_W'(r_idx) + CNT_W'(1)) == r_dcount;
    assign reap_free = r_reap_pend && r_vld[r_rd_addr] && (r_rd_data.st == ST_PENDING)
                       && (r_completed >= r_rd_data.val);
    assign que_we    = i_cmd.submit && (r_req == REQ_DEFER) && (r_dcount < CNT_FULL);

    always_comb begin
        unique case (i_cmd.rd_src)
            RD_IDX:  rd_addr = r_idx;
            RD_REQ:  rd_addr = slot_addr;
            RD_QUE:  rd_addr = r_que_q;
            default: rd_addr = r_idx;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_idx;
        mem_wd = '{st: ST_ENCODING, val: r_counter};
        priority if (i_cmd.take) begin
            mem_we = 1'b1;
        end else if (i_cmd.submit) begin
            mem_we = 1'b1;
            mem_wa = slot_addr;
            mem_wd = '{st: (r_req == REQ_SUBMIT) ? ST_PENDING : ST_DEFERRED, val: r_counter};
        end else if (i_cmd.flush_out) begin
            mem_we = 1'b1;
            mem_wa = r_rd_addr;
            mem_wd = '{st: ST_PENDING, val: r_rd_data.val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_addr <= rd_addr;
        end
        if (que_we) begin
            r_que[r_dcount[IDX_W-1:0]] <= slot_addr;
        end
        if (i_cmd.que_rd) begin
            r_que_q <= r_que[r_idx];
        end
        if (i_cmd.latch) begin
            r_req      <= i_is_query ? REQ_QUERY : i_req_type;
            r_slot_idx <= i_slot_index;
            r_slot_in  <= {1'b0, i_slot_index} < (SLOT_W + 1)'(SLOTS);
            r_fence    <= i_fence_value;
            r_qid      <= i_query_id;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= (r_idx == IDX_MAX) ? r_idx : r_idx + IDX_W'(1);
        end
    end

    always_comb begin
        n_counter = r_counter + ID_W'(1);
        if (n_counter == '0) begin
            n_counter = ID_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reap_pend <= 1'b0;
            r_vld       <= '0;
            r_free      <= CNT_FULL;
            r_counter   <= ID_W'(1);
            r_completed <= '0;
            r_dcount    <= '0;
        end else begin
            r_reap_pend <= i_cmd.reap_rd;
            if (i_cmd.take) begin
                r_vld[r_idx] <= 1'b1;
                r_free       <= r_free - CNT_W'(1);
            end else if (reap_free) begin
                r_vld[r_rd_addr] <= 1'b0;
                r_free           <= r_free + CNT_W'(1);
            end
            if (i_cmd.submit) begin
                r_counter <= n_counter;
            end
            if (i_cmd.set_completed) begin
                r_completed <= r_fence;
            end
            if (que_we) begin
                r_dcount <= r_dcount + CNT_W'(1);
            end else if (i_cmd.flush_clr) begin
                r_dcount <= '0;
            end
        end
    end

    always_comb begin
        n_o_valid  = 1'b0;
        n_o_status = STS_OK;
        n_o_slot   = '0;
        n_o_id     = '0;
        n_o_commit = 1'b0;
        n_o_ready  = 1'b0;
        n_o_last   = 1'b1;
        priority if (i_cmd.take) begin
            n_o_valid = 1'b1;
            n_o_slot  = SLOT_W'(r_idx);
            n_o_id    = r_counter;
        end else if (i_cmd.submit) begin
            n_o_valid  = 1'b1;
            n_o_slot   = r_slot_idx;
            n_o_id     = r_counter;
            n_o_commit = (r_req == REQ_SUBMIT);
        end else if (i_cmd.flush_out) begin
            n_o_valid  = 1'b1;
            n_o_slot   = SLOT_W'(r_rd_addr);
            n_o_id     = r_rd_data.val;
            n_o_commit = 1'b1;
            n_o_last   = fl_last;
        end else begin
            unique case (i_cmd.emit)
                EM_NONE:  n_o_valid = 1'b0;
                EM_BUSY: begin
                    n_o_valid  = 1'b1;
                    n_o_status = STS_BUSY;
                end
                EM_BAD: begin
                    n_o_valid  = 1'b1;
                    n_o_status = STS_BAD_SLOT;
                    n_o_slot   = r_slot_idx;
                end
                EM_DONE:  n_o_valid = 1'b1;
                EM_QUERY: begin
                    n_o_valid = 1'b1;
                    n_o_ready = (r_qid == '0) || (r_completed >= r_qid);
                end
                default:  n_o_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_status <= n_o_status;
        r_o_slot   <= n_o_slot;
        r_o_id     <= n_o_id;
        r_o_commit <= n_o_commit;
        r_o_ready  <= n_o_ready;
        r_o_last   <= n_o_last;
    end

    assign o_sts.req       = r_req;
    assign o_sts.free_zero = (r_free == '0);
    assign o_sts.idx_last  = (r_idx == IDX_MAX);
    assign o_sts.idx_free  = !r_vld[r_idx];
    assign o_sts.slot_ok   = r_slot_in && r_vld[slot_addr] && (r_rd_data.st == ST_ENCODING);
    assign o_sts.dq_empty  = (r_dcount == '0);
    assign o_sts.fl_last   = fl_last;

    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_slot_out  = r_o_slot;
    assign o_submit_id = r_o_id;
    assign o_commit    = r_o_commit;
    assign o_ready_res = r_o_ready;
    assign o_last      = r_o_last;

endmodule

/* src/csft_ctrl.sv */
// ----------------------------------------------------------------------------
// csft_ctrl
// Controller: sequences acquire, submit, defer, flush, completion and query words.
// ----------------------------------------------------------------------------
module csft_ctrl import csft_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DEC   = 10'b0000000010,
        S_FIND  = 10'b0000000100,
        S_CHK   = 10'b0000001000,
        S_REAP  = 10'b0000010000,
        S_DRAIN = 10'b0000100000,
        S_POST  = 10'b0001000000,
        S_FLQ   = 10'b0010000000,
        S_FLS   = 10'b0100000000,
        S_FLO   = 10'b1000000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_sts.req)
                    REQ_ACQUIRE: begin
                        cmd.idx_clr = 1'b1;
                        n_state     = i_sts.free_zero ? S_REAP : S_FIND;
                    end
                    REQ_SUBMIT, REQ_DEFER: begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_src = RD_REQ;
                        n_state    = S_CHK;
                    end
                    REQ_FLUSH: begin
                        if (i_sts.dq_empty) begin
                            n_state = S_IDLE;
                        end else begin
                            cmd.idx_clr = 1'b1;
                            n_state     = S_FLQ;
                        end
                    end
                    REQ_COMPLETE: begin
                        cmd.set_completed = 1'b1;
                        cmd.idx_clr       = 1'b1;
                        n_state           = S_REAP;
                    end
                    REQ_QUERY: begin
                        cmd.emit = EM_QUERY;
                        n_state  = S_IDLE;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_FIND: begin
                if (i_sts.idx_free) begin
                    cmd.take = 1'b1;
                    n_state  = S_IDLE;
                end else if (i_sts.idx_last) begin
                    cmd.emit = EM_BUSY;
                    n_state  = S_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_CHK: begin
                if (i_sts.slot_ok) begin
                    cmd.submit = 1'b1;
                end else begin
                    cmd.emit = EM_BAD;
                end
                n_state = S_IDLE;
            end
            S_REAP: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_src  = RD_IDX;
                cmd.reap_rd = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_DRAIN;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_DRAIN: n_state = S_POST;
            S_POST: begin
                if (i_sts.req == REQ_COMPLETE) begin
                    cmd.emit = EM_DONE;
                    n_state  = S_IDLE;
                end else if (i_sts.free_zero) begin
                    cmd.emit = EM_BUSY;
                    n_state  = S_IDLE;
                end else begin
                    cmd.idx_clr = 1'b1;
                    n_state     = S_FIND;
                end
            end
            S_FLQ: begin
                cmd.que_rd = 1'b1;
                n_state    = S_FLS;
            end
            S_FLS: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_QUE;
                n_state    = S_FLO;
            end
            S_FLO: begin
                cmd.flush_out = 1'b1;
                if (i_sts.fl_last) begin
                    cmd.flush_clr = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_FLQ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

/* src/command_slot_fence_tracker.sv */
// ----------------------------------------------------------------------------
// command_slot_fence_tracker
// Fence-tracked pool of command-buffer slots with a deferred submit queue.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                       Payload
// request   in         i_start high, o_busy low        i_req_type .. i_is_query
// result    out        o_valid high for one cycle      o_status .. o_last
//
// Acquire takes the lowest free slot; when the pool is empty a reclaim scan
// runs first, and busy is reported when the scan frees nothing. Completion
// scans every slot, one slot per cycle through the slot memory read port.
// Flush emits one result word per queued word.
// Synchronous active-low reset frees all slots; no clearing pass is needed.
// Results cannot be held off; each appears on o_valid for one cycle.
// ----------------------------------------------------------------------------
module command_slot_fence_tracker import csft_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [SLOT_W-1:0] i_slot_index,
    input  logic [ID_W-1:0]   i_fence_value,
    input  logic [ID_W-1:0]   i_query_id,
    input  logic              i_is_query,
    output logic              o_valid,
    output logic [STS_W-1:0]  o_status,
    output logic [SLOT_W-1:0] o_slot_out,
    output logic [ID_W-1:0]   o_submit_id,
    output logic              o_commit,
    output logic              o_ready_res,
    output logic              o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    csft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    csft_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_slot_index  (i_slot_index),
        .i_fence_value (i_fence_value),
        .i_query_id    (i_query_id),
        .i_is_query    (i_is_query),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot_out    (o_slot_out),
        .o_submit_id   (o_submit_id),
        .o_commit      (o_commit),
        .o_ready_res   (o_ready_res),
        .o_last        (o_last)
    );

endmodule

/* tb/tb_command_slot_fence_tracker.sv */
// ----------------------------------------------------------------------------
// tb_command_slot_fence_tracker
// Self-checking bench for the command slot fence tracker. A short table of
// directed words covers reset state, field extremes, bad slots, empty and
// non-empty flushes, queries and completion updates. Random words follow in
// alternating fill and drain phases, so that the pool runs empty, reclaims
// and reports busy. An in-bench model of the slot pool predicts every
// result word, and each o_valid word is checked field by field.
// ----------------------------------------------------------------------------
module tb_command_slot_fence_tracker;
    import csft_pkg::*;

    localparam int SLOTS          = 64;
    localparam int RANDOM_WORDS   = 207;
    localparam int PHASE_LEN      = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int MAX_REPORTS    = 10;

    localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;
    localparam logic [ID_W-1:0]  ONES         = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   fence;
        logic [ID_W-1:0]   qid;
        logic              isq;
    } t_cmd_word;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        logic              commit;
        logic              ready;
        logic              last;
    } t_res_word;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   fence;
        logic [ID_W-1:0]   qid;
        logic              isq;
        logic              typed;
        logic [STS_W-1:0]  e_status;
        logic [SLOT_W-1:0] e_slot;
        logic [ID_W-1:0]   e_id;
        logic              e_commit;
        logic              e_ready;
        logic              e_last;
    } t_row;

    localparam int DIR_ROWS = 23;
    localparam t_row DIR_TAB [DIR_ROWS] = '{
        '{REQ_QUERY,    6'd0,  32'd0, 32'd0, 1'b0,
          1'b1, STS_OK,       6'd0,  32'd0, 1'b0, 1'b1, 1'b1},
        '{REQ_ACQUIRE,  6'd63, ONES,  ONES,  1'b1,
          1'b1, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b1},
        '{REQ_SUBMIT,   6'd0,  ONES,  32'd0, 1'b0,
          1'b1, STS_BAD_SLOT, 6'd0,  32'd0, 1'b0, 1'b0, 1'b1},
        '{REQ_DEFER,    6'd63, 32'd0, ONES,  1'b0,
          1'b1, STS_BAD_SLOT, 6'd63, 32'd0, 1'b0, 1'b0, 1'b1},
        '{REQ_FLUSH,    6'd63, ONES,  ONES,  1'b0,
          1'b0, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b0},
        '{REQ_UNUSED_6, 6'd0,  32'd0, 32'd0, 1'b0,
          1'b0, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b0},
        '{REQ_UNUSED_7, 6'd63, ONES,  ONES,  1'b0,
          1'b0, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b0},
        '{REQ_ACQUIRE,  6'd63, ONES,  ONES,  1'b0,
          1'b1, STS_OK,       6'd0,  32'd1, 1'b0, 1'b0, 1'b1},
        '{REQ_ACQUIRE,  6'd0,  32'd0, 32'd0, 1'b0,
          1'b1, STS_OK,       6'd1,  32'd1, 1'b0, 1'b0, 1'b1},
        '{REQ_SUBMIT,   6'd0,  32'd0, 32'd0, 1'b0,
          1'b1, STS_OK,       6'd0,  32'd1, 1'b1, 1'b0, 1'b1},
        '{REQ_SUBMIT,   6'd0,  ONES,  ONES,  1'b0,
          1'b1, STS_BAD_SLOT, 6'd0,  32'd0, 1'b0, 1'b0, 1'b1},
        '{REQ_DEFER,    6'd1,  32'd0, 32'd0, 1'b0,
          1'b0, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b0},
        '{REQ_ACQUIRE,  6'd0,  32'd0, 32'd0, 1'b0,
          1'b0, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b0},
        '{REQ_DEFER,    6'd2,  ONES,  ONES,  1'b0,
          1'b0, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b0},
        '{REQ_FLUSH,    6'd0,  32'd0, 32'd0, 1'b0,
          1'b0, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b0},
        '{REQ_QUERY,    6'd0,  32'd0, 32'd2, 1'b0,
          1'b0, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b0},
        '{REQ_COMPLETE, 6'd0,  ONES,  32'd0, 1'b0,
          1'b1, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b1},
        '{REQ_QUERY,    6'd63, 32'd0, ONES,  1'b0,
          1'b1, STS_OK,       6'd0,  32'd0, 1'b0, 1'b1, 1'b1},
        '{REQ_COMPLETE, 6'd63, 32'd0, ONES,  1'b0,
          1'b1, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b1},
        '{REQ_COMPLETE, 6'd0,  32'd5, 32'd1, 1'b1,
          1'b0, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b0},
        '{REQ_ACQUIRE,  6'd0,  32'd0, 32'd0, 1'b0,
          1'b0, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b0},
        '{REQ_SUBMIT,   6'd63, 32'd0, 32'd0, 1'b0,
          1'b1, STS_BAD_SLOT, 6'd63, 32'd0, 1'b0, 1'b0, 1'b1},
        '{REQ_FLUSH,    6'd0,  32'd0, 32'd0, 1'b0,
          1'b0, STS_OK,       6'd0,  32'd0, 1'b0, 1'b0, 1'b0}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic [REQ_W-1:0]  i_req_type;
    logic [SLOT_W-1:0] i_slot_index;
    logic [ID_W-1:0]   i_fence_value;
    logic [ID_W-1:0]   i_query_id;
    logic              i_is_query;
    logic              o_valid;
    logic [STS_W-1:0]  o_status;
    logic [SLOT_W-1:0] o_slot_out;
    logic [ID_W-1:0]   o_submit_id;
    logic              o_commit;
    logic              o_ready_res;
    logic              o_last;

    t_slot_st        pool_st    [SLOTS];
    logic [ID_W-1:0] pool_stamp [SLOTS];
    logic [5:0]      defer_fifo [SLOTS];
    logic [ID_W-1:0] next_stamp;
    logic [ID_W-1:0] fence_seen;
    int              defer_len;
    int              free_left;

    t_res_word fresh_words[$];
    t_res_word expected_words[$];
    int        err_count;
    int        idle_run;

    command_slot_fence_tracker #(.SLOTS(SLOTS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_req_type    (i_req_type),
        .i_slot_index  (i_slot_index),
        .i_fence_value (i_fence_value),
        .i_query_id    (i_query_id),
        .i_is_query    (i_is_query),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot_out    (o_slot_out),
        .o_submit_id   (o_submit_id),
        .o_commit      (o_commit),
        .o_ready_res   (o_ready_res),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic note_word(input t_res_word r);
        fresh_words.insert(fresh_words.size(), r);
    endtask

    task automatic reap_finished();
        for (int i = 0; i < SLOTS; i++) begin
            if (pool_st[i] == ST_PENDING && fence_seen >= pool_stamp[i]) begin
                pool_st[i] = ST_FREE;
                free_left++;
            end
        end
    endtask

    task automatic apply_to_pool(input t_cmd_word w);
        t_res_word r;
        int        s;
        fresh_words.delete();
        r = '0;
        r.last = 1'b1;
        if (w.isq || w.req == REQ_QUERY) begin
            r.ready = (w.qid == '0) || (fence_seen >= w.qid);
            note_word(r);
        end else begin
            case (w.req)
                REQ_ACQUIRE: begin
                    if (free_left == 0)
                        reap_finished();
                    s = -1;
                    for (int i = SLOTS - 1; i >= 0; i--) begin
                        if (pool_st[i] == ST_FREE)
                            s = i;
                    end
                    if (free_left == 0 || s < 0) begin
                        r.status = STS_BUSY;
                    end else begin
                        pool_st[s] = ST_ENCODING;
                        free_left--;
                        r.slot = SLOT_W'(s);
                        r.id   = next_stamp;
                    end
                    note_word(r);
                end
                REQ_SUBMIT, REQ_DEFER: begin
                    r.slot = w.slot;
                    if (int'(w.slot) >= SLOTS || pool_st[w.slot] != ST_ENCODING) begin
                        r.status = STS_BAD_SLOT;
                    end else begin
                        pool_stamp[w.slot] = next_stamp;
                        r.id = next_stamp;
                        if (w.req == REQ_SUBMIT) begin
                            pool_st[w.slot] = ST_PENDING;
                            r.commit        = 1'b1;
                        end else begin
                            pool_st[w.slot] = ST_DEFERRED;
                            if (defer_len < SLOTS) begin
                                defer_fifo[defer_len] = w.slot;
                                defer_len++;
                            end
                        end
                        next_stamp = next_stamp + ID_W'(1);
                        if (next_stamp == '0)
                            next_stamp = ID_W'(1);
                    end
                    note_word(r);
                end
                REQ_FLUSH: begin
                    for (int i = 0; i < defer_len; i++) begin
                        s = int'(defer_fifo[i]);
                        pool_st[s] = ST_PENDING;
                        r.slot   = SLOT_W'(s);
                        r.id     = pool_stamp[s];
                        r.commit = 1'b1;
                        r.last   = (i == defer_len - 1);
                        note_word(r);
                    end
                    defer_len = 0;
                end
                REQ_COMPLETE: begin
                    fence_seen = w.fence;
                    reap_finished();
                    note_word(r);
                end
                default: begin
                end
            endcase
        end
    endtask

    function automatic int pick_encoding();
        int list[$];
        for (int i = 0; i < SLOTS; i++) begin
            if (pool_st[i] == ST_ENCODING)
                list.insert(list.size(), i);
        end
        if (list.size() == 0)
            return -1;
        return list[$urandom_range(0, list.size() - 1)];
    endfunction

    function automatic t_cmd_word pick_word(input bit fill);
        t_cmd_word w;
        int        roll;
        int        s;
        w.req   = REQ_ACQUIRE;
        w.slot  = SLOT_W'($urandom);
        w.fence = $urandom;
        w.qid   = $urandom;
        w.isq   = 1'b0;
        roll    = $urandom_range(0, 99);
        if (roll < (fill ? 50 : 25)) begin
            w.req = REQ_ACQUIRE;
        end else if (roll < (fill ? 70 : 55)) begin
            w.req = ($urandom_range(0, 2) == 0) ? REQ_DEFER : REQ_SUBMIT;
            s = pick_encoding();
            if (s >= 0)
                w.slot = SLOT_W'(s);
        end else if (roll < (fill ? 78 : 63)) begin
            w.req = REQ_FLUSH;
        end else if (roll < (fill ? 82 : 80)) begin
            w.req = REQ_COMPLETE;
            case ($urandom_range(0, 5))
                0, 1:    w.fence = next_stamp - 1 - $urandom_range(0, 6);
                2:       w.fence = next_stamp + $urandom_range(0, 30);
                3:       w.fence = fence_seen;
                4:       w.fence = '0;
                default: w.fence = $urandom;
            endcase
        end else if (roll < 92) begin
            w.isq = 1'($urandom_range(0, 1));
            if (!w.isq)
                w.req = REQ_QUERY;
            else
                w.req = REQ_W'($urandom);
            case ($urandom_range(0, 3))
                0:       w.qid = '0;
                1:       w.qid = $urandom;
                default: w.qid = next_stamp - $urandom_range(0, 12);
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0:       w.req = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
                1:       w.req = REQ_SUBMIT;
                default: w.req = REQ_DEFER;
            endcase
        end
        return w;
    endfunction

    task automatic send_word(input t_cmd_word w, input bit typed, input t_res_word want);
        @(negedge i_clk);
        i_start       <= 1'b1;
        i_req_type    <= w.req;
        i_slot_index  <= w.slot;
        i_fence_value <= w.fence;
        i_query_id    <= w.qid;
        i_is_query    <= w.isq;
        do @(posedge i_clk); while (o_busy);
        apply_to_pool(w);
        if (typed)
            expected_words.insert(expected_words.size(), want);
        else
            foreach (fresh_words[k])
                expected_words.insert(expected_words.size(), fresh_words[k]);
    endtask

    task automatic idle_for(input int n);
        @(negedge i_clk);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic report(input string what, input t_res_word want, input t_res_word got);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $write("%s: exp sts=%0d slot=%0d id=%h com=%b rdy=%b last=%b",
                   what, want.status, want.slot, want.id, want.commit, want.ready,
                   want.last);
            $display(" | got sts=%0d slot=%0d id=%h com=%b rdy=%b last=%b",
                     got.status, got.slot, got.id, got.commit, got.ready, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_res_word got;
        t_res_word want;
        if (i_rst_n && o_valid) begin
            got = '{o_status, o_slot_out, o_submit_id, o_commit, o_ready_res, o_last};
            if (expected_words.size() == 0) begin
                report("unexpected result word", '0, got);
            end else begin
                want = expected_words.pop_front();
                if (got.status !== want.status || got.slot !== want.slot
                        || got.id !== want.id || got.commit !== want.commit
                        || got.ready !== want.ready || got.last !== want.last)
                    report("result word mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            idle_run <= 0;
        end else if (idle_run >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    initial begin
        t_row      row;
        t_cmd_word w;
        t_res_word want;
        bit        fill;
        bit        calm;
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_req_type     = REQ_ACQUIRE;
        i_slot_index   = '0;
        i_fence_value  = '0;
        i_query_id     = '0;
        i_is_query     = 1'b0;
        err_count      = 0;
        idle_run       = 0;
        next_stamp     = ID_W'(1);
        fence_seen     = '0;
        defer_len      = 0;
        free_left      = SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
            pool_st[i]    = ST_FREE;
            pool_stamp[i] = '0;
            defer_fifo[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIR_ROWS; n++) begin
            row  = DIR_TAB[n];
            w    = '{row.req, row.slot, row.fence, row.qid, row.isq};
            want = '{row.e_status, row.e_slot, row.e_id, row.e_commit, row.e_ready, row.e_last};
            if ($urandom_range(0, 2) == 0)
                idle_for($urandom_range(1, 9));
            send_word(w, row.typed, want);
        end
        wait_for_results();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n != 0 && n % PHASE_LEN == 0)
                wait_for_results();
            fill = ((n / PHASE_LEN) % 2) == 0;
            calm = n >= RANDOM_WORDS - PHASE_LEN;
            if (!calm && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 9));
            send_word(pick_word(fill), 1'b0, '0);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && expected_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
